@@ src/polyphonic_voice_allocator_adsr_top_defines.svh @@
// Assertion helpers for the voice allocator checker
`ifndef POLYPHONIC_VOICE_ALLOCATOR_ADSR_TOP_DEFINES_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_ADSR_TOP_DEFINES_SVH

// Clocked check, idle during reset
`define PVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds through reset
`define PVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/pva_pkg.sv @@
package pva_pkg;

  localparam logic [15:0] AMP_FULL = 16'hFFFF;

  localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
  localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;

  localparam logic [19:0] ATTACK_RST  = 20'd4410;
  localparam logic [19:0] DECAY_RST   = 20'd4410;
  localparam logic [15:0] SUSTAIN_RST = 16'd45875;
  localparam logic [19:0] RELEASE_RST = 20'd8820;

  localparam logic [4:0] DIV_STEPS = 5'd16;

  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_ON,
    S_ALLOC,
    S_SCAN_OFF,
    S_OFF_EMIT,
    S_DIV_START,
    S_DIV,
    S_TICK_UPD,
    S_WAIT_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_on;
    logic alloc;
    logic scan_off;
    logic emit_off;
    logic div_start;
    logic tick_upd;
    logic cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       last_voice;
    logic       div_idle;
    logic       out_taken;
  } sts_t;

endpackage

@@ src/pva_if.sv @@
interface pva_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [6:0]  note;
  logic [15:0] velocity;
  modport source (output valid, req_type, note, velocity, input ready);
  modport sink   (input valid, req_type, note, velocity, output ready);
endinterface

interface pva_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  voice;
  logic [15:0] gain;
  logic [2:0]  stage;
  logic [7:0]  released_mask;
  logic        last;
  modport source (output valid, voice, gain, stage, released_mask, last, input ready);
  modport sink   (input valid, voice, gain, stage, released_mask, last, output ready);
endinterface

interface pva_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/pva_ctrl.sv @@
module pva_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic [1:0]    req_type_i,
  output logic          req_ready_o,
  input  pva_pkg::sts_t sts_i,
  output pva_pkg::cmd_t cmd_o
);
  import pva_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          case (req_type_i)
            REQ_NOTE_ON:  state_d = S_SCAN_ON;
            REQ_NOTE_OFF: state_d = S_SCAN_OFF;
            REQ_TICK:     state_d = S_DIV_START;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN_ON:   if (sts_i.last_voice) state_d = S_ALLOC;
      S_ALLOC:     state_d = S_WAIT_OUT;
      S_SCAN_OFF:  if (sts_i.last_voice) state_d = S_OFF_EMIT;
      S_OFF_EMIT:  state_d = S_WAIT_OUT;
      S_DIV_START: state_d = S_DIV;
      S_DIV:       if (sts_i.div_idle) state_d = S_TICK_UPD;
      S_TICK_UPD:  state_d = S_WAIT_OUT;
      S_WAIT_OUT: begin
        if (sts_i.out_taken) begin
          if (sts_i.req_type == REQ_TICK && !sts_i.last_voice) state_d = S_DIV_START;
          else state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      S_SCAN_ON: begin
        cmd_o.scan_on = 1'b1;
        cmd_o.cnt_inc = !sts_i.last_voice;
      end
      S_ALLOC: cmd_o.alloc = 1'b1;
      S_SCAN_OFF: begin
        cmd_o.scan_off = 1'b1;
        cmd_o.cnt_inc  = !sts_i.last_voice;
      end
      S_OFF_EMIT:  cmd_o.emit_off = 1'b1;
      S_DIV_START: cmd_o.div_start = 1'b1;
      S_TICK_UPD:  cmd_o.tick_upd = 1'b1;
      S_WAIT_OUT: begin
        cmd_o.cnt_inc = sts_i.out_taken && sts_i.req_type == REQ_TICK && !sts_i.last_voice;
      end
      default: ;
    endcase
  end

endmodule

@@ src/pva_dp.sv @@
module pva_dp #(
  parameter int unsigned VOICES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [1:0]                     req_type_i,
  input  logic [6:0]                     note_i,
  input  logic [15:0]                    velocity_i,
  input  logic                           cfg_valid_i,
  input  logic [pva_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pva_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                           res_ready_i,
  output logic                           res_valid_o,
  output logic [5:0]                     voice_o,
  output logic [15:0]                    gain_o,
  output logic [2:0]                     stage_o,
  output logic [7:0]                     released_mask_o,
  output logic                           last_o,
  input  pva_pkg::cmd_t                  cmd_i,
  output pva_pkg::sts_t                  sts_o
);
  import pva_pkg::*;

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VW-1:0] LAST_IDX = VW'(VOICES - 1);

  logic [19:0] attack_q, decay_q, release_q;
  logic [15:0] sustain_q;

  logic [6:0]  note_q [VOICES];
  logic [15:0] vel_q  [VOICES];
  stage_e      stg_q  [VOICES];
  logic [15:0] amp_q  [VOICES];
  logic [19:0] el_q   [VOICES];
  logic [15:0] rs_q   [VOICES];

  logic [1:0]    req_type_q;
  logic [6:0]    in_note_q;
  logic [15:0]   in_vel_q;
  logic [VW-1:0] cnt_q;

  logic          off_found_q, rel_found_q;
  logic [VW-1:0] off_idx_q, rel_idx_q, best_idx_q;
  logic [19:0]   best_q;
  logic [7:0]    mask_q;

  logic [20:0] rem_q;
  logic [15:0] quo_q;
  logic [19:0] dvs_q;
  logic [4:0]  dcnt_q;

  logic        res_valid_q, last_q;
  logic [5:0]  voice_q;
  logic [15:0] gain_q;
  logic [2:0]  stage_q;
  logic [7:0]  rmask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= ATTACK_RST;
      decay_q   <= DECAY_RST;
      sustain_q <= SUSTAIN_RST;
      release_q <= RELEASE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ATTACK:  attack_q  <= cfg_data_i;
        CFG_DECAY:   decay_q   <= cfg_data_i;
        CFG_SUSTAIN: sustain_q <= cfg_data_i[15:0];
        CFG_RELEASE: release_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Current voice, read through the scan counter
  stage_e      cur_stg;
  logic [15:0] cur_amp;
  logic [19:0] cur_el;
  logic [20:0] el_inc;
  logic [VW-1:0] alloc_idx;

  assign cur_stg = stg_q[cnt_q];
  assign cur_amp = amp_q[cnt_q];
  assign cur_el  = el_q[cnt_q];
  assign el_inc  = {1'b0, cur_el} + 21'd1;
  assign alloc_idx = off_found_q ? off_idx_q : (rel_found_q ? rel_idx_q : best_idx_q);

  // Divider operands; a duration of zero acts as one
  logic [15:0] dvd;
  logic [19:0] dvs;
  always_comb begin
    dvd = '0;
    dvs = 20'd1;
    case (cur_stg)
      ST_ATTACK: begin
        dvd = AMP_FULL;
        dvs = (attack_q == '0) ? 20'd1 : attack_q;
      end
      ST_DECAY: begin
        dvd = AMP_FULL - sustain_q;
        dvs = (decay_q == '0) ? 20'd1 : decay_q;
      end
      ST_RELEASE: begin
        dvd = rs_q[cnt_q];
        dvs = (release_q == '0) ? 20'd1 : release_q;
      end
      default: ;
    endcase
  end

  logic [20:0] rem_sh;
  assign rem_sh = {rem_q[19:0], quo_q[15]};

  // One envelope step for the current voice
  stage_e      nxt_stg;
  logic [15:0] nxt_amp;
  logic [19:0] nxt_el;
  logic        clr_rs;
  logic [16:0] amp_sum;
  logic [31:0] prod;
  assign amp_sum = {1'b0, cur_amp} + {1'b0, quo_q};
  always_comb begin
    nxt_stg = cur_stg;
    nxt_amp = cur_amp;
    nxt_el  = cur_el;
    clr_rs  = 1'b0;
    case (cur_stg)
      ST_ATTACK: begin
        nxt_amp = amp_sum[16] ? AMP_FULL : amp_sum[15:0];
        nxt_el  = el_inc[19:0];
        if (el_inc >= {1'b0, dvs}) begin
          nxt_amp = AMP_FULL;
          nxt_stg = ST_DECAY;
          nxt_el  = '0;
        end
      end
      ST_DECAY: begin
        nxt_amp = (cur_amp > quo_q) ? cur_amp - quo_q : 16'd0;
        nxt_el  = el_inc[19:0];
        if (el_inc >= {1'b0, dvs}) begin
          nxt_amp = sustain_q;
          nxt_stg = ST_SUSTAIN;
          nxt_el  = '0;
        end
      end
      ST_RELEASE: begin
        nxt_amp = (cur_amp > quo_q) ? cur_amp - quo_q : 16'd0;
        nxt_el  = el_inc[19:0];
        if (el_inc >= {1'b0, dvs}) begin
          nxt_amp = '0;
          nxt_stg = ST_OFF;
          nxt_el  = '0;
          clr_rs  = 1'b1;
        end
      end
      default: ;
    endcase
  end
  assign prod = nxt_amp * vel_q[cnt_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        note_q[i] <= '0;
        vel_q[i]  <= '0;
        stg_q[i]  <= ST_OFF;
        amp_q[i]  <= '0;
        el_q[i]   <= '0;
        rs_q[i]   <= '0;
      end
    end else if (cmd_i.alloc) begin
      note_q[alloc_idx] <= in_note_q;
      vel_q[alloc_idx]  <= in_vel_q;
      stg_q[alloc_idx]  <= ST_ATTACK;
      amp_q[alloc_idx]  <= '0;
      el_q[alloc_idx]   <= '0;
      rs_q[alloc_idx]   <= '0;
    end else if (cmd_i.scan_off) begin
      if (note_q[cnt_q] == in_note_q &&
          (cur_stg == ST_ATTACK || cur_stg == ST_DECAY || cur_stg == ST_SUSTAIN)) begin
        stg_q[cnt_q] <= ST_RELEASE;
        el_q[cnt_q]  <= '0;
        rs_q[cnt_q]  <= cur_amp;
      end
    end else if (cmd_i.tick_upd) begin
      stg_q[cnt_q] <= nxt_stg;
      amp_q[cnt_q] <= nxt_amp;
      el_q[cnt_q]  <= nxt_el;
      if (clr_rs) rs_q[cnt_q] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_type_q  <= '0;
      cnt_q       <= '0;
      off_found_q <= 1'b0;
      rel_found_q <= 1'b0;
      dcnt_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        req_type_q  <= req_type_i;
        cnt_q       <= '0;
        off_found_q <= 1'b0;
        rel_found_q <= 1'b0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + VW'(1);
      end
      if (cmd_i.scan_on) begin
        if (cur_stg == ST_OFF && !off_found_q) off_found_q <= 1'b1;
        if (cur_stg == ST_RELEASE && !rel_found_q) rel_found_q <= 1'b1;
      end
      if (cmd_i.div_start) dcnt_q <= DIV_STEPS;
      else if (dcnt_q != '0) dcnt_q <= dcnt_q - 5'd1;
      if (cmd_i.alloc || cmd_i.emit_off || cmd_i.tick_upd) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_note_q <= note_i;
      in_vel_q  <= velocity_i;
      mask_q    <= '0;
    end
    if (cmd_i.scan_on) begin
      if (cur_stg == ST_OFF && !off_found_q) off_idx_q <= cnt_q;
      if (cur_stg == ST_RELEASE && !rel_found_q) rel_idx_q <= cnt_q;
      if (cnt_q == '0 || cur_el > best_q) begin
        best_q     <= cur_el;
        best_idx_q <= cnt_q;
      end
    end
    if (cmd_i.scan_off && note_q[cnt_q] == in_note_q &&
        (cur_stg == ST_ATTACK || cur_stg == ST_DECAY || cur_stg == ST_SUSTAIN)) begin
      mask_q <= mask_q | (8'd1 << cnt_q);
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= dvd;
      dvs_q <= dvs;
    end else if (dcnt_q != '0) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_q <= rem_sh - {1'b0, dvs_q};
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
    if (cmd_i.alloc) begin
      voice_q <= 6'(alloc_idx);
      gain_q  <= '0;
      stage_q <= ST_ATTACK;
      rmask_q <= '0;
      last_q  <= 1'b1;
    end else if (cmd_i.emit_off) begin
      voice_q <= '0;
      gain_q  <= '0;
      stage_q <= ST_OFF;
      rmask_q <= mask_q;
      last_q  <= 1'b1;
    end else if (cmd_i.tick_upd) begin
      voice_q <= 6'(cnt_q);
      gain_q  <= (cur_stg == ST_OFF) ? 16'd0 : prod[31:16];
      stage_q <= nxt_stg;
      rmask_q <= '0;
      last_q  <= (cnt_q == LAST_IDX);
    end
  end

  assign res_valid_o     = res_valid_q;
  assign voice_o         = voice_q;
  assign gain_o          = gain_q;
  assign stage_o         = stage_q;
  assign released_mask_o = rmask_q;
  assign last_o          = last_q;

  assign sts_o.req_type   = req_type_q;
  assign sts_o.last_voice = (cnt_q == LAST_IDX);
  assign sts_o.div_idle   = (dcnt_q == '0);
  assign sts_o.out_taken  = res_valid_q && res_ready_i;

endmodule

@@ src/polyphonic_voice_allocator_adsr_top.sv @@
// Channel | Dir | Carries
// req     | in  | req_type, note, velocity
// res     | out | voice, gain, stage, released_mask, last
// cfg     | in  | index, data (always ready)
//
// Note on / note off: accept, a scan of every voice in turn, result load,
// hand-off; the result is registered at the result load.
// Tick, for each voice in turn: start, the 16-step serial divider for the
// envelope step, update, hand-off.
// One item in flight; a result left waiting for res.ready stalls the item.
// Reset clears every voice to off and the envelope settings to their defaults.
module polyphonic_voice_allocator_adsr_top #(
  parameter int unsigned VOICES = 8
) (
  input logic      clk_i,
  input logic      rst_ni,
  pva_req_if.sink  req,
  pva_res_if.source res,
  pva_cfg_if.sink  cfg
);
  import pva_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  pva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_type_i  (req.req_type),
    .req_ready_o (req.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pva_dp #(.VOICES(VOICES)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_type_i      (req.req_type),
    .note_i          (req.note),
    .velocity_i      (req.velocity),
    .cfg_valid_i     (cfg.valid),
    .cfg_index_i     (cfg.index),
    .cfg_data_i      (cfg.data),
    .res_ready_i     (res.ready),
    .res_valid_o     (res.valid),
    .voice_o         (res.voice),
    .gain_o          (res.gain),
    .stage_o         (res.stage),
    .released_mask_o (res.released_mask),
    .last_o          (res.last),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

@@ src/pva_chk.sv @@
`include "polyphonic_voice_allocator_adsr_top_defines.svh"

module pva_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_gain,
  input logic [2:0]  res_stage,
  input logic [7:0]  res_released_mask
);
  import pva_pkg::*;

  logic mask_seen;
  logic off_clean;

  assign mask_seen = res_valid && res_released_mask != 8'd0;
  assign off_clean = res_stage == ST_OFF && res_gain == 16'd0;

  `PVA_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
  `PVA_ASSERT(a_one_item, req_valid && req_ready |-> !res_valid, "item taken with result pending")
  `PVA_ASSERT(a_mask_only_off, mask_seen |-> off_clean, "note off result carries tick fields")
  `PVA_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !res_valid, "result valid in reset")

endmodule

bind polyphonic_voice_allocator_adsr_top pva_chk u_pva_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_gain          (res.gain),
  .res_stage         (res.stage),
  .res_released_mask (res.released_mask)
);
